[rtl/mpbs_pkg.sv]
package mpbs_pkg;

  localparam int unsigned SizeW  = 16;
  localparam int unsigned SeqW   = 32;
  localparam int unsigned TryW   = 4;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam logic [SizeW-1:0] ReplyLen       = 16'd4;
  localparam logic [SizeW-1:0] MinMtuReset    = 16'd576;
  localparam logic [SizeW-1:0] MaxMtuReset    = 16'd1500;
  localparam logic [TryW-1:0]  RetryLimReset  = 4'd6;
  localparam logic [SizeW-1:0] DoneGapReset   = 16'd16;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_REPLY = 1'b1
  } opcode_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MIN_MTU   = 2'd0,
    CFG_MAX_MTU   = 2'd1,
    CFG_RETRY_LIM = 2'd2,
    CFG_DONE_GAP  = 2'd3
  } cfg_idx_t;

  // classified event as held in the queue
  typedef struct packed {
    logic            is_reply;
    logic            len_ok;
    logic [SeqW-1:0] reply_index;
  } mpbs_entry_t;

endpackage

[rtl/mpbs_if.sv]
interface mpbs_in_if;
  import mpbs_pkg::*;
  logic             valid;
  logic             ready;
  logic             opcode;
  logic [SeqW-1:0]  reply_index;
  logic [SizeW-1:0] reply_length;

  modport source (output valid, opcode, reply_index, reply_length, input ready);
  modport sink   (input valid, opcode, reply_index, reply_length, output ready);
endinterface

interface mpbs_out_if;
  import mpbs_pkg::*;
  logic             valid;
  logic             ready;
  logic             probe_valid;
  logic [SizeW-1:0] probe_size;
  logic [SeqW-1:0]  probe_index;
  logic             reply_accepted;
  logic [SizeW-1:0] new_mtu;
  logic             search_done;

  modport source (output valid, probe_valid, probe_size, probe_index, reply_accepted,
                  new_mtu, search_done, input ready);
  modport sink   (input valid, probe_valid, probe_size, probe_index, reply_accepted,
                  new_mtu, search_done, output ready);
endinterface

[rtl/mpbs_front.sv]
module mpbs_front (
  input  logic                  clk,
  input  logic                  rst_n,
  mpbs_in_if.sink               in_ch,
  output logic                  q_valid,
  output mpbs_pkg::mpbs_entry_t q_head,
  input  logic                  q_pop
);
  import mpbs_pkg::*;

  mpbs_entry_t            mem_r [QDepth];
  logic [QPtrW-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [QPtrW-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [QCntW-1:0]       cnt_r, cnt_nxt;
  logic                   push;
  mpbs_entry_t            entry;

  // classify: decode opcode and check reply length up front
  always_comb begin
    entry.is_reply    = (opcode_t'(in_ch.opcode) == OP_REPLY);
    entry.len_ok      = (in_ch.reply_length == ReplyLen);
    entry.reply_index = in_ch.reply_index;
  end

  assign in_ch.ready = (cnt_r != QCntW'(QDepth));
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (cnt_r != '0);
  assign q_head      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, q_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= entry;
    end
  end

endmodule

[rtl/mpbs_back.sv]
module mpbs_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  input  mpbs_pkg::mpbs_entry_t        q_head,
  output logic                         q_pop,
  input  logic                         cfg_we,
  input  logic [mpbs_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [mpbs_pkg::CfgW-1:0]    cfg_wdata,
  mpbs_out_if.source                   out_ch
);
  import mpbs_pkg::*;

  logic [SizeW-1:0] min_r, min_nxt;
  logic [SizeW-1:0] max_r, max_nxt;
  logic [TryW-1:0]  retry_r, retry_nxt;
  logic [SizeW-1:0] gap_r, gap_nxt;

  logic [SizeW-1:0] lower_r, lower_nxt;
  logic [SizeW-1:0] upper_r, upper_nxt;
  logic [SizeW-1:0] cur_r, cur_nxt;
  logic [SeqW-1:0]  seq_r, seq_nxt;
  logic [TryW-1:0]  try_r, try_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic             pv_r, pv_nxt;
  logic [SizeW-1:0] psize_r, psize_nxt;
  logic [SeqW-1:0]  pindex_r, pindex_nxt;
  logic             acc_r, acc_nxt;
  logic [SizeW-1:0] mtu_r, mtu_nxt;
  logic             done_r, done_nxt;

  logic             exhaust, send, match;
  logic [SizeW-1:0] upper_dec, tick_upper, tick_cur, reply_cur;
  logic [SizeW:0]   sum_tick, sum_reply, lim_lower, lim_cur;
  logic             tick_in_gap, reply_in_gap, hold_in_gap;
  logic             restart;

  assign q_pop = q_valid && (!out_valid_r || out_ch.ready);

  // tick path: retries exhausted lowers the upper bound and bisects, otherwise the probe repeats at the current size
  always_comb begin
    exhaust     = (try_r >= retry_r);
    upper_dec   = (cur_r == '0) ? '0 : cur_r - 1'b1;
    tick_upper  = exhaust ? upper_dec : upper_r;
    sum_tick    = {1'b0, lower_r} + {1'b0, upper_dec};
    tick_cur    = exhaust ? sum_tick[SizeW:1] : cur_r;
    lim_lower   = {1'b0, lower_r} + {1'b0, gap_r};
    tick_in_gap = ({1'b0, tick_upper} <= lim_lower);
    hold_in_gap = ({1'b0, upper_r} <= lim_lower);
    send        = !tick_in_gap;
  end

  // reply path: matching reply raises the lower bound to the current size
  always_comb begin
    match        = q_head.len_ok && (q_head.reply_index == seq_r);
    sum_reply    = {1'b0, cur_r} + {1'b0, upper_r};
    reply_cur    = sum_reply[SizeW:1];
    lim_cur      = {1'b0, cur_r} + {1'b0, gap_r};
    reply_in_gap = ({1'b0, upper_r} <= lim_cur);
  end

  always_comb begin
    min_nxt   = min_r;
    max_nxt   = max_r;
    retry_nxt = retry_r;
    gap_nxt   = gap_r;
    restart   = 1'b0;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MIN_MTU: begin
          min_nxt = cfg_wdata;
          restart = 1'b1;
        end
        CFG_MAX_MTU: begin
          max_nxt = cfg_wdata;
          restart = 1'b1;
        end
        CFG_RETRY_LIM: retry_nxt = cfg_wdata[TryW-1:0];
        CFG_DONE_GAP:  gap_nxt   = cfg_wdata;
        default:       restart   = 1'b0;
      endcase
    end
  end

  always_comb begin
    lower_nxt     = lower_r;
    upper_nxt     = upper_r;
    cur_nxt       = cur_r;
    seq_nxt       = seq_r;
    try_nxt       = try_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    pv_nxt        = pv_r;
    psize_nxt     = psize_r;
    pindex_nxt    = pindex_r;
    acc_nxt       = acc_r;
    mtu_nxt       = mtu_r;
    done_nxt      = done_r;
    if (restart) begin
      lower_nxt = min_nxt;
      upper_nxt = max_nxt;
      cur_nxt   = min_nxt;
      try_nxt   = '0;
    end else if (q_pop) begin
      out_valid_nxt = 1'b1;
      pv_nxt        = 1'b0;
      psize_nxt     = '0;
      pindex_nxt    = '0;
      acc_nxt       = 1'b0;
      mtu_nxt       = '0;
      done_nxt      = hold_in_gap;
      if (!q_head.is_reply) begin
        upper_nxt = tick_upper;
        cur_nxt   = tick_cur;
        seq_nxt   = seq_r + SeqW'(exhaust);
        done_nxt  = tick_in_gap;
        if (exhaust) begin
          try_nxt = send ? TryW'(1) : '0;
        end else if (send) begin
          try_nxt = try_r + 1'b1;
        end
        if (send) begin
          pv_nxt     = 1'b1;
          psize_nxt  = tick_cur;
          pindex_nxt = seq_r + SeqW'(exhaust);
        end
      end else if (match) begin
        try_nxt   = '0;
        seq_nxt   = seq_r + 1'b1;
        lower_nxt = cur_r;
        cur_nxt   = reply_cur;
        acc_nxt   = 1'b1;
        mtu_nxt   = cur_r;
        done_nxt  = reply_in_gap;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r       <= MinMtuReset;
      max_r       <= MaxMtuReset;
      retry_r     <= RetryLimReset;
      gap_r       <= DoneGapReset;
      lower_r     <= MinMtuReset;
      upper_r     <= MaxMtuReset;
      cur_r       <= MinMtuReset;
      seq_r       <= '0;
      try_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      retry_r     <= retry_nxt;
      gap_r       <= gap_nxt;
      lower_r     <= lower_nxt;
      upper_r     <= upper_nxt;
      cur_r       <= cur_nxt;
      seq_r       <= seq_nxt;
      try_r       <= try_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pv_r     <= pv_nxt;
    psize_r  <= psize_nxt;
    pindex_r <= pindex_nxt;
    acc_r    <= acc_nxt;
    mtu_r    <= mtu_nxt;
    done_r   <= done_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.probe_valid    = pv_r;
  assign out_ch.probe_size     = psize_r;
  assign out_ch.probe_index    = pindex_r;
  assign out_ch.reply_accepted = acc_r;
  assign out_ch.new_mtu        = mtu_r;
  assign out_ch.search_done    = done_r;

endmodule

[rtl/mtu_probe_binary_search.sv]
// path: an accepted transaction is written into the queue, then popped into the output register
// once that register is free or drains; its result is held there until taken
// throughput: one transaction per cycle while the output is not stalled, set by the search update in the back end
// a two-entry queue sits between the classifier and the search update
// reset (rst_n low at a clock edge, synchronous): registers back to 576/1500/6/16,
// bounds and probe size reloaded, sequence and retry count cleared, queue and output empty
module mtu_probe_binary_search (
  input  logic                         clk,
  input  logic                         rst_n,
  mpbs_in_if.sink                      in_ch,
  mpbs_out_if.source                   out_ch,
  input  logic                         cfg_we,
  input  logic [mpbs_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [mpbs_pkg::CfgW-1:0]    cfg_wdata
);
  import mpbs_pkg::*;

  // handoff between the front (classify + queue) and the back (search state)
  logic        q_valid;
  logic        q_pop;
  mpbs_entry_t q_head;

  // front: decodes the opcode, checks reply length, queues the event
  mpbs_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop)
  );

  // back: holds bounds, sequence and retry count, bisects, drives the
  // registered result; it pops whenever the output register is free or drains
  mpbs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_ch    (out_ch)
  );

endmodule

[rtl/mpbs_checker.sv]
module mpbs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        probe_valid,
  input logic [15:0] probe_size,
  input logic [31:0] probe_index,
  input logic        reply_accepted,
  input logic [15:0] new_mtu
);

  // a pending result stays until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // an event never both asks for a probe and confirms an mtu
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(probe_valid && reply_accepted))
    else $error("probe and accepted reply in one transaction");

  // no probe means zero size and index
  a_probe_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !probe_valid |-> (probe_size == '0) && (probe_index == '0))
    else $error("probe fields nonzero without probe");

  // no accepted reply means no mtu
  a_mtu_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !reply_accepted |-> (new_mtu == '0))
    else $error("new mtu nonzero without accepted reply");

endmodule

bind mtu_probe_binary_search mpbs_checker u_mpbs_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .probe_valid    (out_ch.probe_valid),
  .probe_size     (out_ch.probe_size),
  .probe_index    (out_ch.probe_index),
  .reply_accepted (out_ch.reply_accepted),
  .new_mtu        (out_ch.new_mtu)
);

[test/mtu_probe_binary_search_test.sv]
`timescale 1ns / 100ps

module mtu_probe_binary_search_test;
  import mpbs_pkg::*;

  // cycles without any transaction before the run is declared hung
  localparam int unsigned QuietLimit = 2000;
  // mismatch lines printed before going quiet (all are still counted)
  localparam int unsigned PrintCap   = 30;
  localparam int unsigned RandPhases = 12;
  localparam int unsigned PhaseLen   = 36;
  // random phase that runs with both sides never idling
  localparam int unsigned CalmPhase  = 5;

  // one event presented to the prober
  typedef struct packed {
    opcode_t          op;
    logic [SeqW-1:0]  index;
    logic [SizeW-1:0] length;
  } mtu_input_t;

  // one decision coming back from the prober
  typedef struct packed {
    logic             probe_valid;
    logic [SizeW-1:0] probe_size;
    logic [SeqW-1:0]  probe_index;
    logic             reply_accepted;
    logic [SizeW-1:0] new_mtu;
    logic             search_done;
  } mtu_result_t;

  // register file plus the search variables
  typedef struct packed {
    logic [SizeW-1:0] min_start, max_start, gap;
    logic [TryW-1:0]  retry_lim;
    logic [SizeW-1:0] lower, upper, cur;
    logic [SeqW-1:0]  seq;
    logic [TryW-1:0]  tries;
  } search_state_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgW-1:0]    cfg_wdata;

  mpbs_in_if  in_ch ();
  mpbs_out_if out_ch ();

  mtu_probe_binary_search DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // tracked follows accepted transactions, planned runs ahead as events are queued
  search_state_t tracked;
  search_state_t planned;

  mtu_input_t  pending_events[$];
  mtu_result_t awaited_results[$];

  bit          in_taken;
  bit          out_taken;
  bit          calm;
  int unsigned quiet;
  int unsigned errors;
  int unsigned n_events, n_results, n_probes, n_accepts, n_done, n_writes;

  always #5 clk = ~clk;

  // bounds count as converged when upper sits within the gap above lower,
  // which also covers crossed bounds
  function automatic logic bounds_close(search_state_t s);
    return 32'(s.upper) <= 32'(s.lower) + 32'(s.gap);
  endfunction

  function automatic bit take_break();
    return !calm && ($urandom_range(0, 99) < 38);
  endfunction

  task automatic restart(inout search_state_t s);
    s.lower = s.min_start;
    s.upper = s.max_start;
    s.cur   = s.min_start;
    s.tries = '0;
  endtask

  // one step of the search: tick retries or lowers the upper bound,
  // a matching four-byte reply raises the lower bound
  task automatic advance_search(inout search_state_t s, input mtu_input_t e,
                                output mtu_result_t r);
    logic [SizeW:0] total;
    logic           send;
    r = '0;
    if (e.op == OP_TICK) begin
      send = 1'b1;
      if (s.tries >= s.retry_lim) begin
        // retries used up: current size is too large
        s.tries = '0;
        s.seq   = s.seq + 1;
        s.upper = (s.cur == '0) ? '0 : s.cur - 1'b1;
        total   = {1'b0, s.lower} + {1'b0, s.upper};
        s.cur   = total[SizeW:1];
        if (bounds_close(s)) send = 1'b0;
      end else if (bounds_close(s)) begin
        send = 1'b0;
      end
      if (send) begin
        s.tries       = s.tries + 1'b1;
        r.probe_valid = 1'b1;
        r.probe_size  = s.cur;
        r.probe_index = s.seq;
      end
    end else if (e.length == ReplyLen && e.index == s.seq) begin
      s.tries          = '0;
      s.seq            = s.seq + 1;
      s.lower          = s.cur;
      total            = {1'b0, s.lower} + {1'b0, s.upper};
      s.cur            = total[SizeW:1];
      r.reply_accepted = 1'b1;
      r.new_mtu        = s.lower;
    end
    r.search_done = bounds_close(s);
  endtask

  task automatic flag_error(string msg);
    errors++;
    if (errors <= PrintCap) $display("ERROR @%0t: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [SeqW-1:0] got, logic [SeqW-1:0] want);
    if (got !== want) flag_error($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  // register write, only issued while nothing is in flight
  task automatic write_reg(cfg_idx_t idx, logic [CfgW-1:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_MIN_MTU: begin
        tracked.min_start = v;
        restart(tracked);
      end
      CFG_MAX_MTU: begin
        tracked.max_start = v;
        restart(tracked);
      end
      CFG_RETRY_LIM: tracked.retry_lim = v[TryW-1:0];
      CFG_DONE_GAP:  tracked.gap = v;
      default: ;
    endcase
    planned = tracked;
    n_writes++;
  endtask

  task automatic queue_event(opcode_t op, logic [SeqW-1:0] idx, logic [SizeW-1:0] len);
    mtu_input_t  e;
    mtu_result_t unused;
    e.op     = op;
    e.index  = idx;
    e.length = len;
    advance_search(planned, e, unused);
    pending_events.push_back(e);
  endtask

  // tick with random reply fields, which the block must ignore
  task automatic queue_tick();
    queue_event(OP_TICK, $urandom, 16'($urandom));
  endtask

  task automatic queue_good_reply();
    queue_event(OP_REPLY, planned.seq, ReplyLen);
  endtask

  // wait until every queued event is through and its result checked,
  // then leave the pipeline time to go quiet
  task automatic settle();
    while (pending_events.size() != 0 || awaited_results.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  // input driver: hold a presented transaction until taken, otherwise
  // present the next one or idle at random
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!(in_ch.valid && !in_taken)) begin
      if (pending_events.size() != 0 && !take_break()) begin
        in_ch.valid        <= 1'b1;
        in_ch.opcode       <= pending_events[0].op;
        in_ch.reply_index  <= pending_events[0].index;
        in_ch.reply_length <= pending_events[0].length;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
    out_ch.ready <= rst_n && !take_break();
  end

  // monitor: check results against the oldest expectation, predict on
  // every accepted event, and watch for a hang
  always @(posedge clk) begin : monitor
    mtu_result_t want;
    in_taken  = rst_n && in_ch.valid && in_ch.ready;
    out_taken = rst_n && out_ch.valid && out_ch.ready;
    if (out_taken) begin
      if (awaited_results.size() == 0) begin
        flag_error("result transaction with nothing expected");
      end else begin
        want = awaited_results.pop_front();
        check_field("probe_valid", SeqW'(out_ch.probe_valid), SeqW'(want.probe_valid));
        check_field("probe_size", SeqW'(out_ch.probe_size), SeqW'(want.probe_size));
        check_field("probe_index", out_ch.probe_index, want.probe_index);
        check_field("reply_accepted", SeqW'(out_ch.reply_accepted),
                    SeqW'(want.reply_accepted));
        check_field("new_mtu", SeqW'(out_ch.new_mtu), SeqW'(want.new_mtu));
        check_field("search_done", SeqW'(out_ch.search_done), SeqW'(want.search_done));
        n_results++;
        if (want.probe_valid) n_probes++;
        if (want.reply_accepted) n_accepts++;
        if (want.search_done) n_done++;
      end
    end
    if (in_taken) begin
      advance_search(tracked, pending_events[0], want);
      pending_events.delete(0);
      awaited_results.push_back(want);
      n_events++;
    end
    if (!rst_n || in_taken || out_taken) quiet = 0;
    else quiet++;
    if (quiet >= QuietLimit) begin
      $display("watchdog: no transaction for %0d cycles", QuietLimit);
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned pick;
    int unsigned lo;
    clk               = 1'b0;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = CFG_MIN_MTU;
    cfg_wdata         = '0;
    in_ch.valid        = 1'b0;
    in_ch.opcode       = OP_TICK;
    in_ch.reply_index  = '0;
    in_ch.reply_length = '0;
    out_ch.ready      = 1'b0;
    calm              = 1'b0;
    in_taken          = 1'b0;
    out_taken         = 1'b0;
    quiet             = 0;
    errors            = 0;
    n_events = 0; n_results = 0; n_probes = 0; n_accepts = 0; n_done = 0; n_writes = 0;

    // register values after reset
    tracked.min_start = MinMtuReset;
    tracked.max_start = MaxMtuReset;
    tracked.retry_lim = RetryLimReset;
    tracked.gap       = DoneGapReset;
    tracked.seq       = '0;
    restart(tracked);
    planned = tracked;

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: first probe, rejected replies, a matching reply,
    // then a tick whose reply fields must be ignored
    queue_tick();
    queue_event(OP_REPLY, planned.seq, 16'd5);
    queue_event(OP_REPLY, planned.seq + 1, ReplyLen);
    queue_event(OP_REPLY, '1, '1);
    queue_good_reply();
    queue_event(OP_TICK, '1, ReplyLen);
    settle();

    // everything at zero: no retries, upper bound clamps at zero,
    // then a reply after the search has finished
    write_reg(CFG_MIN_MTU, '0);
    write_reg(CFG_MAX_MTU, '0);
    write_reg(CFG_RETRY_LIM, '0);
    write_reg(CFG_DONE_GAP, '0);
    queue_tick();
    queue_good_reply();
    settle();

    // crossed bounds count as done
    write_reg(CFG_MIN_MTU, 16'd1000);
    write_reg(CFG_MAX_MTU, 16'd10);
    write_reg(CFG_RETRY_LIM, 16'd1);
    queue_tick();
    queue_good_reply();
    settle();

    // top of every range
    write_reg(CFG_MIN_MTU, '1);
    write_reg(CFG_MAX_MTU, '1);
    write_reg(CFG_RETRY_LIM, '1);
    write_reg(CFG_DONE_GAP, '1);
    queue_tick();
    queue_good_reply();
    settle();

    // build up retries, then lower the limit under the retry count
    write_reg(CFG_MIN_MTU, '0);
    write_reg(CFG_MAX_MTU, '1);
    write_reg(CFG_DONE_GAP, '0);
    repeat (5) queue_tick();
    settle();
    write_reg(CFG_RETRY_LIM, 16'd2);
    queue_tick();
    queue_tick();
    settle();

    // random phases: mostly well-formed probe/reply traffic with some noise
    for (int unsigned ph = 0; ph < RandPhases; ph++) begin
      if (ph == 0 || $urandom_range(0, 2) != 0) begin
        pick = $urandom_range(0, 3);
        case (pick)
          0: begin
            lo = $urandom_range(0, 1500);
            write_reg(CFG_MIN_MTU, 16'(lo));
            write_reg(CFG_MAX_MTU, 16'(lo + $urandom_range(0, 8000)));
          end
          1: begin
            write_reg(CFG_MIN_MTU, 16'($urandom));
            write_reg(CFG_MAX_MTU, 16'($urandom));
          end
          2: begin
            write_reg(CFG_MIN_MTU, 16'($urandom_range(0, 200)));
            write_reg(CFG_MAX_MTU, 16'($urandom_range(60000, 65535)));
          end
          default: begin
            write_reg(CFG_MIN_MTU, MinMtuReset);
            write_reg(CFG_MAX_MTU, MaxMtuReset);
          end
        endcase
      end
      // limits alone keep the current search going
      if ($urandom_range(0, 3) == 0) write_reg(CFG_RETRY_LIM, 16'($urandom_range(0, 15)));
      else write_reg(CFG_RETRY_LIM, 16'($urandom_range(0, 3)));
      pick = $urandom_range(0, 3);
      if (pick == 0) write_reg(CFG_DONE_GAP, '0);
      else if (pick == 3) write_reg(CFG_DONE_GAP, 16'($urandom));
      else write_reg(CFG_DONE_GAP, 16'($urandom_range(0, 64)));

      calm = (ph == CalmPhase);
      for (int unsigned k = 0; k < PhaseLen; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
          queue_tick();
        end else if (pick < 78) begin
          queue_good_reply();
        end else begin
          // broken reply: wrong index, wrong length, or both random
          case ($urandom_range(0, 2))
            0: queue_event(OP_REPLY, planned.seq ^ (32'd1 << $urandom_range(0, 31)), ReplyLen);
            1: begin
              lo = $urandom_range(0, 65535);
              if (16'(lo) == ReplyLen) lo = 65535;
              queue_event(OP_REPLY, planned.seq, 16'(lo));
            end
            default: queue_event(OP_REPLY, $urandom, 16'($urandom));
          endcase
        end
      end
      settle();
      calm = 1'b0;
    end

    // give stray results a chance to show up
    repeat (8) @(negedge clk);
    if (awaited_results.size() != 0)
      flag_error($sformatf("%0d results never arrived", awaited_results.size()));

    $display("covered %0d events across %0d register writes: %0d probes, %0d replies accepted",
             n_events, n_writes, n_probes, n_accepts);
    $display("%0d results checked, %0d with the search converged, %0d mismatches",
             n_results, n_done, errors);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
